>>> rtl/mpq_pkg.sv
// Package for the min priority queue scan unit.
// Holds the shared widths, codes, state type and the controller/datapath structs.
// Depends on nothing; the RTL files refer to it by scoped names, the simulation files import it.
`default_nettype none

package mpq_pkg;

   // Default number of queue slots.
   localparam int DEPTH_DEFAULT = 8;

   // Fixed payload widths.
   localparam int VALUE_W = 32;
   localparam int OCC_W   = 4;

   // Request command codes.
   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       insert_write;
      logic       scan_init;
      logic       scan_run;
      logic       shift_run;
      logic       finish_remove;
      logic       load_result;
      status_type result_status;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_remove;
      logic full;
      logic empty;
      logic scan_done;
      logic shift_done;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/mpq_ifs.sv
// Channel interfaces of the min priority queue scan unit.
// Request and result channels, each with valid/ready and payload; uses mpq_pkg.
`default_nettype none

interface mpq_req_if;
   logic                                valid;
   logic                                ready;
   mpq_pkg::command_type                command;
   logic signed [mpq_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface mpq_rsp_if;
   logic                                valid;
   logic                                ready;
   mpq_pkg::status_type                 status;
   logic signed [mpq_pkg::VALUE_W-1:0]  removed_value;
   logic [mpq_pkg::OCC_W-1:0]           occupancy;

   modport source (output valid, output status, output removed_value, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input occupancy,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/mpq_ctrl.sv
// Controller state machine of the min priority queue scan unit.
// Sequences insert, scan and shift and owns the result valid flag; uses mpq_pkg.
`default_nettype none

module mpq_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  mpq_pkg::dp_stat_type  stat,
   output mpq_pkg::ctrl_cmd_type cmd
);

   mpq_pkg::state_type state_ff;
   mpq_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_free;

   // The result slot can take a new result when empty or being drained now.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mpq_pkg::ST_EXEC;
            end
         end
         mpq_pkg::ST_EXEC: begin
            if (stat.op_remove && !stat.empty) begin
               state_in = mpq_pkg::ST_SCAN;
            end else if (rsp_free) begin
               state_in = mpq_pkg::ST_IDLE;
            end
         end
         mpq_pkg::ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = mpq_pkg::ST_SHIFT;
            end
         end
         mpq_pkg::ST_SHIFT: begin
            if (stat.shift_done && rsp_free) begin
               state_in = mpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpq_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs to the datapath and the request channel.
   always_comb begin
      cmd       = '0;
      cmd.result_status = mpq_pkg::STATUS_DONE;
      req_ready = 1'b0;
      unique case (state_ff)
         mpq_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         mpq_pkg::ST_EXEC: begin
            if (stat.op_remove && !stat.empty) begin
               cmd.scan_init = 1'b1;
            end else if (rsp_free) begin
               cmd.load_result = 1'b1;
               if (stat.op_remove) begin
                  cmd.result_status = mpq_pkg::STATUS_EMPTY;
               end else if (stat.full) begin
                  cmd.result_status = mpq_pkg::STATUS_OVERFLOW;
               end else begin
                  cmd.insert_write  = 1'b1;
               end
            end
         end
         mpq_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         mpq_pkg::ST_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (stat.shift_done && rsp_free) begin
               cmd.load_result   = 1'b1;
               cmd.finish_remove = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result valid flag: set on a new result, cleared when the transaction completes.
   always_comb begin
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/mpq_datapath.sv
// Datapath of the min priority queue scan unit.
// Entry memory, fill count, scan/shift address counter, minimum tracking and
// result registers; driven by mpq_ctrl through mpq_pkg structs.
`default_nettype none

module mpq_datapath #(
   parameter int DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  mpq_pkg::ctrl_cmd_type               cmd,
   input  mpq_pkg::command_type                req_command,
   input  wire signed [mpq_pkg::VALUE_W-1:0]   req_value,
   output mpq_pkg::dp_stat_type                stat,
   output mpq_pkg::status_type                 rsp_status,
   output logic signed [mpq_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic [mpq_pkg::OCC_W-1:0]           rsp_occupancy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Entry memory: one write and one registered read per cycle.
   logic signed [mpq_pkg::VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [mpq_pkg::VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]                   rd_tag_ff;
   logic                               rd_vld_ff;
   logic                               rd_vld_in;
   logic                               rd_en;
   logic                               wr_en;
   logic [IDX_W-1:0]                   wr_addr;
   logic signed [mpq_pkg::VALUE_W-1:0] wr_data;

   // Captured request.
   mpq_pkg::command_type               op_ff;
   logic signed [mpq_pkg::VALUE_W-1:0] value_ff;

   // Counters and scan result.
   logic [CNT_W-1:0]                   fill_ff;
   logic [CNT_W-1:0]                   fill_in;
   logic [CNT_W-1:0]                   issue_ff;
   logic [CNT_W-1:0]                   issue_in;
   logic signed [mpq_pkg::VALUE_W-1:0] best_ff;
   logic signed [mpq_pkg::VALUE_W-1:0] best_in;
   logic [IDX_W-1:0]                   pos_ff;
   logic [IDX_W-1:0]                   pos_in;
   logic                               more_to_read;
   logic                               last_tag;

   // Result registers.
   mpq_pkg::status_type                res_status_ff;
   logic signed [mpq_pkg::VALUE_W-1:0] res_removed_ff;
   logic [mpq_pkg::OCC_W-1:0]          res_occ_ff;

   assign more_to_read = issue_ff < fill_ff;
   assign last_tag     = CNT_W'(rd_tag_ff) == (fill_ff - CNT_W'(1));
   assign rd_en        = (cmd.scan_run || cmd.shift_run) && more_to_read;
   assign rd_vld_in    = rd_en;

   // Status toward the controller.
   always_comb begin
      stat.op_remove  = op_ff == mpq_pkg::CMD_REMOVE;
      stat.full       = fill_ff == CNT_W'(DEPTH);
      stat.empty      = fill_ff == '0;
      stat.scan_done  = rd_vld_ff && last_tag;
      stat.shift_done = !more_to_read && !rd_vld_ff;
   end

   // Fill count update.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.insert_write) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.finish_remove) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   // Running minimum; strict compare keeps the earliest of equal values.
   always_comb begin
      best_in = best_ff;
      pos_in  = pos_ff;
      if (cmd.scan_run && rd_vld_ff) begin
         if ((rd_tag_ff == '0) || (rd_data_ff < best_ff)) begin
            best_in = rd_data_ff;
            pos_in  = rd_tag_ff;
         end
      end
   end

   // Read address counter. After the scan it restarts just past the minimum.
   always_comb begin
      issue_in = issue_ff;
      if (cmd.scan_init) begin
         issue_in = '0;
      end else if (cmd.scan_run && stat.scan_done) begin
         issue_in = CNT_W'(pos_in) + CNT_W'(1);
      end else if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end
   end

   // Write port: an insert appends; a shift moves an entry down one slot.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff[IDX_W-1:0];
      wr_data = value_ff;
      if (cmd.insert_write) begin
         wr_en = 1'b1;
      end else if (cmd.shift_run && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_tag_ff - IDX_W'(1);
         wr_data = rd_data_ff;
      end
   end

   // Memory array.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[issue_ff[IDX_W-1:0]];
         rd_tag_ff  <= issue_ff[IDX_W-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         issue_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_command;
         value_ff <= req_value;
      end
      best_ff <= best_in;
      pos_ff  <= pos_in;
      if (cmd.load_result) begin
         res_status_ff <= cmd.result_status;
         if ((cmd.result_status == mpq_pkg::STATUS_DONE) && stat.op_remove) begin
            res_removed_ff <= best_ff;
         end else begin
            res_removed_ff <= '0;
         end
         res_occ_ff <= mpq_pkg::OCC_W'(fill_in);
      end
   end

   assign rsp_status        = res_status_ff;
   assign rsp_removed_value = res_removed_ff;
   assign rsp_occupancy     = res_occ_ff;

endmodule

`default_nettype wire

>>> rtl/min_priority_queue_scan_unit.sv
// Top level of the min priority queue scan unit.
// Joins mpq_ctrl and mpq_datapath to the request and result interfaces of mpq_ifs.sv.
// An ascending priority queue of DEPTH signed 32-bit values in a single-port-read
// memory. An insert appends the value. A remove on a queue of n entries reads all n
// entries through the memory read port to find the minimum (earliest on ties), then
// streams the entries after slot p of the minimum down by one.
// One transaction is in work at a time; a result waits in an output register so
// the next request is taken while the previous result has not yet been collected.
// The occupancy field reports the count after the step, masked to four bits.
// The entry memory has no reset and needs no clearing pass.
`default_nettype none

module min_priority_queue_scan_unit #(
   parameter int DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   mpq_req_if.sink     req_chan,
   mpq_rsp_if.source   rsp_chan
);

   mpq_pkg::ctrl_cmd_type cmd;
   mpq_pkg::dp_stat_type  stat;

   // Sequencer.
   mpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and compare.
   mpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_command       (req_chan.command),
      .req_value         (req_chan.value),
      .stat              (stat),
      .rsp_status        (rsp_chan.status),
      .rsp_removed_value (rsp_chan.removed_value),
      .rsp_occupancy     (rsp_chan.occupancy)
   );

`ifndef NO_ASSERTIONS
   // A new result never overwrites one that has not been collected.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result loaded over a pending result");

   // An insert is never written into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      cmd.insert_write |-> !stat.full)
      else $error("insert written into a full queue");

   // An overflow result reports a full queue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == mpq_pkg::STATUS_OVERFLOW)) |->
         (rsp_chan.occupancy == mpq_pkg::OCC_W'(DEPTH)))
      else $error("overflow reported with a queue that is not full");

   // An empty result reports zero occupancy and no removed value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == mpq_pkg::STATUS_EMPTY)) |->
         ((rsp_chan.occupancy == '0) && (rsp_chan.removed_value == '0)))
      else $error("empty reported with stored entries or a removed value");
`endif

endmodule

`default_nettype wire

>>> sim/mpq_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the min priority queue scan unit testbench.
// Holds the expected result record and the class that predicts and checks results; uses mpq_pkg.
package mpq_check_pkg;
   import mpq_pkg::*;

   // One result transaction as the block should return it.
   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  removed_value;
      logic [OCC_W-1:0]           occupancy;
   } queue_result_type;

   class min_queue_scoreboard;
      int unsigned                depth;
      logic signed [VALUE_W-1:0]  stored_values[$];
      queue_result_type           expected_results[$];
      int unsigned                error_count;

      function new(int unsigned depth_in);
         depth = depth_in;
         error_count = 0;
      endfunction

      // Apply an accepted request to the local copy of the queue and record
      // the result it must produce.
      function void note_request(command_type cmd, logic signed [VALUE_W-1:0] value);
         queue_result_type res;
         int unsigned      min_pos;
         int unsigned      idx;
         res.status = STATUS_DONE;
         res.removed_value = '0;
         if (cmd == CMD_INSERT) begin
            if (stored_values.size() >= depth) begin
               res.status = STATUS_OVERFLOW;
            end else begin
               stored_values.push_back(value);
            end
         end else if (stored_values.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            // Strict less-than keeps the earliest of equal minima.
            min_pos = 0;
            for (idx = 1; idx < stored_values.size(); idx++) begin
               if (stored_values[idx] < stored_values[min_pos]) begin
                  min_pos = idx;
               end
            end
            res.removed_value = stored_values[min_pos];
            stored_values.delete(min_pos);
         end
         res.occupancy = OCC_W'(stored_values.size());
         expected_results.push_back(res);
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      // Compare a result transaction with the oldest expected one.
      function void check_response(status_type status, logic signed [VALUE_W-1:0] removed,
                                   logic [OCC_W-1:0] occupancy);
         queue_result_type exp;
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: status=%0d removed=%0d occupancy=%0d",
                     $time, status, removed, occupancy);
            error_count++;
            return;
         end
         exp = expected_results.pop_front();
         if (status !== exp.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp.status, status);
            error_count++;
         end
         if (removed !== exp.removed_value) begin
            $display("%0t: removed_value mismatch: expected %0d, actual %0d",
                     $time, exp.removed_value, removed);
            error_count++;
         end
         if (occupancy !== exp.occupancy) begin
            $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                     $time, exp.occupancy, occupancy);
            error_count++;
         end
      endfunction
   endclass

endpackage

>>> sim/min_priority_queue_scan_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the min priority queue scan unit.
// Drives random and directed insert/remove transactions; depends on mpq_pkg, mpq_ifs, mpq_check_pkg.
module min_priority_queue_scan_unit_tb;
   import mpq_pkg::*;
   import mpq_check_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_COUNT = 16;
   localparam int PHASE_ITEMS = 100;

   logic clock;
   logic reset;
   bit   req_steady;
   bit   rsp_steady;
   int unsigned cycle_count;

   mpq_req_if req_bus();
   mpq_rsp_if rsp_bus();

   min_queue_scoreboard sb;

   min_priority_queue_scan_unit #(
      .DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Free-running clock, 8 ns period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle cycles before a transaction; steady stretches use none.
   function automatic int draw_gap(bit steady);
      if (steady) begin
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // Mix of wide random values, small values that tie often, and extremes.
   function automatic logic signed [VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7) - 4;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Send one request; valid stays high after acceptance so a back-to-back
   // transaction needs no second assignment in the same step.
   task automatic send_request(input command_type cmd, input logic signed [VALUE_W-1:0] value);
      int gap;
      gap = draw_gap(req_steady);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.command = cmd;
      req_bus.value = value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Result side: random stalls before taking each result.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(rsp_steady);
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Monitor both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.command, req_bus.value);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response(rsp_bus.status, rsp_bus.removed_value, rsp_bus.occupancy);
         end
      end
   end

   // Watchdog on total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Main sequence: reset, directed transactions, random phases, drain.
   initial begin
      int          phase;
      int          item;
      int          insert_pct;
      command_type cmd;
      sb = new(QUEUE_DEPTH);
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_INSERT;
      req_bus.value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Remove on an empty queue, then fill with extremes and ties.
      send_request(CMD_REMOVE, 32'sh5555_5555);
      send_request(CMD_INSERT, 32'sh7FFF_FFFF);
      send_request(CMD_INSERT, 32'sh8000_0000);
      send_request(CMD_INSERT, 32'sh0000_0000);
      send_request(CMD_INSERT, -32'sd1);
      send_request(CMD_INSERT, 32'sd5);
      send_request(CMD_INSERT, 32'sd5);
      send_request(CMD_INSERT, 32'sh8000_0000);
      send_request(CMD_INSERT, 32'shAAAA_AAAA);
      // Insert on a full queue reports overflow.
      send_request(CMD_INSERT, 32'sd1);
      // Drain in ascending order, then remove once more from empty.
      repeat (4) send_request(CMD_REMOVE, 32'shAAAA_AAAA);
      repeat (4) send_request(CMD_REMOVE, 32'sh5555_5555);
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_INSERT, -32'sd7);
      send_request(CMD_INSERT, 32'sh5555_5555);
      send_request(CMD_REMOVE, -32'sd1);
      send_request(CMD_REMOVE, 32'sh7FFF_FFFF);

      // Random phases with different insert/remove balance so the queue
      // spends time full, empty and in between.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case ($urandom_range(0, 3))
            0: insert_pct = 80;
            1: insert_pct = 20;
            2: insert_pct = 50;
            default: insert_pct = $urandom_range(10, 90);
         endcase
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            send_request(cmd, draw_value());
         end
      end
      req_bus.valid = 1'b0;
      rsp_steady = 1'b0;

      // Wait for every expected result, then a little longer for strays.
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * QUEUE_DEPTH + 10) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
